### hdl/dna_multi_pattern_matcher_core_defines.svh
// Assertion macros used by the checker file.
`ifndef DNA_MULTI_PATTERN_MATCHER_CORE_DEFINES_SVH
`define DNA_MULTI_PATTERN_MATCHER_CORE_DEFINES_SVH
// Assert that a condition implies a consequence in the next cycle.
`define DMPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
// Assert that a condition implies a consequence in the same cycle.
`define DMPM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`endif

### hdl/dmpm_pkg.sv
// ----------------------------------------------------------------------------
// dmpm_pkg
// Action codes, base codes and payload types of the DNA pattern matcher.
// ----------------------------------------------------------------------------
package dmpm_pkg;
    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_BUILD  = 2'd2;
    localparam logic [1:0] ACT_MATCH  = 2'd3;

    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_T = 2'd1;
    localparam logic [1:0] BASE_C = 2'd2;
    localparam logic [1:0] BASE_G = 2'd3;

    localparam int MASK_W = 10;
    localparam int NODE_W = 10;

    typedef struct packed {
        logic [1:0]         action;
        logic [1:0]         base;
        logic               pattern_end;
        logic [3:0]         pattern_id;
        logic signed [31:0] weight;
    } t_req;

    typedef struct packed {
        logic               status;
        logic [MASK_W-1:0]  matched_mask;
        logic signed [31:0] match_weight;
        logic [NODE_W-1:0]  node;
    } t_rsp;
endpackage

### hdl/dmpm_if.sv
// ----------------------------------------------------------------------------
// dmpm_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface dmpm_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/dmpm_mem.sv
// ----------------------------------------------------------------------------
// dmpm_mem
// Node memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dmpm_mem #(
    parameter int AW = 10,
    parameter int DW = 55
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### hdl/dna_multi_pattern_matcher_core.sv
// ----------------------------------------------------------------------------
// dna_multi_pattern_matcher_core: Aho-Corasick matcher over the DNA alphabet
// One request at a time: the next is taken only after the response register is loaded.
// Reset (sync, active low) clears node memory with ready held low.
// ----------------------------------------------------------------------------
module dna_multi_pattern_matcher_core
    import dmpm_pkg::*;
#(
    parameter int NODES    = 1024,
    parameter int PATTERNS = 10
) (
    input  logic i_clk,
    input  logic i_rst_n,
    dmpm_if.sink   i_req,
    dmpm_if.source o_rsp
);
    // A single node memory, with one write port and one registered read port,
    // paces all work; the read address is registered, then the read data.
    // A link hop in match (fail walk or output chain) passes a read, a wait and a step state.
    // Build pops the queued nodes in breadth-first order; for each present child
    // it walks fail links from the parent's fail node, moves on to the child of
    // the node found, and writes the child's fail link and output mark.
    // The response sits in its own register, so a stalled response does not
    // hold off the next request.
    localparam int AW = $clog2(NODES);
    localparam int PW = 4;
    // memory word: child[4] (4*AW), fail (AW), pattern (4), has_output (1)
    localparam int DW = 5 * AW + PW + 1;
    localparam int CW = $clog2(PATTERNS + 1);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_CLEAR  = 5'd1;
    localparam logic [4:0] S_IRD    = 5'd2;
    localparam logic [4:0] S_IWAIT  = 5'd3;
    localparam logic [4:0] S_IUPD   = 5'd4;
    localparam logic [4:0] S_INEW   = 5'd5;
    localparam logic [4:0] S_MRD    = 5'd6;
    localparam logic [4:0] S_MWAIT  = 5'd7;
    localparam logic [4:0] S_MSTEP  = 5'd8;
    localparam logic [4:0] S_ORD    = 5'd9;
    localparam logic [4:0] S_OWAIT  = 5'd10;
    localparam logic [4:0] S_OSTEP  = 5'd11;
    localparam logic [4:0] S_SUM    = 5'd12;
    localparam logic [4:0] S_OUT    = 5'd13;
    localparam logic [4:0] S_BPOP   = 5'd14;
    localparam logic [4:0] S_BUWAIT = 5'd15;
    localparam logic [4:0] S_BUGOT  = 5'd16;
    localparam logic [4:0] S_BVWAIT = 5'd17;
    localparam logic [4:0] S_BVGOT  = 5'd18;
    localparam logic [4:0] S_BPWAIT = 5'd19;
    localparam logic [4:0] S_BPGOT  = 5'd20;
    localparam logic [4:0] S_BWV    = 5'd21;
    localparam logic [4:0] S_BNEXT  = 5'd22;
    localparam logic [4:0] S_BINIT  = 5'd23;

    // Node word field access
    function automatic logic [AW-1:0] f_child(input logic [DW-1:0] w, input logic [1:0] k);
        return w[k*AW +: AW];
    endfunction

    logic [4:0]      r_state;
    logic            r_init;     // clearing pass after reset, no response
    t_req            r_req;
    t_rsp            r_rsp;
    t_rsp            r_out;
    logic            r_out_valid;
    logic [AW:0]     r_node_count;
    logic [AW-1:0]   r_cursor;
    logic [AW-1:0]   r_match;
    logic [AW:0]     r_clr;
    logic [AW-1:0]   r_cur;      // node under work
    logic [DW-1:0]   r_word;     // captured word of r_cur
    logic [AW:0]     r_hops;     // bounded link walks
    logic [PATTERNS-1:0] r_mask;
    logic [CW-1:0]   r_sum_i;
    logic [31:0]     r_sum;
    logic [31:0]     r_pw [PATTERNS];
    // build bookkeeping
    logic [AW-1:0]   r_q [NODES];
    logic [AW-1:0]   r_qrd;
    logic [AW:0]     r_head;
    logic [AW:0]     r_tail;
    logic [AW-1:0]   r_u;
    logic [DW-1:0]   r_uword;
    logic [1:0]      r_k;
    logic [AW-1:0]   r_v;
    logic            r_qwe;
    logic [AW-1:0]   r_qwa;
    logic [AW-1:0]   r_qwd;

    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    logic [DW-1:0]   mem_wd;
    logic [AW-1:0]   mem_ra;
    logic [DW-1:0]   mem_rd;

    dmpm_mem #(.AW(AW), .DW(DW)) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_wa),
        .i_wdata(mem_wd),
        .i_raddr(mem_ra),
        .o_rdata(mem_rd)
    );

    // Queue memory for breadth-first order
    always_ff @(posedge i_clk) begin
        if (r_qwe) begin
            r_q[r_qwa] <= r_qwd;
        end
        r_qrd <= r_q[r_head[AW-1:0]];
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    logic [AW-1:0] w_fail;
    logic [PW-1:0] w_pat;
    logic          w_has;
    logic [AW-1:0] w_rd_child;
    assign w_fail     = mem_rd[4*AW +: AW];
    assign w_pat      = mem_rd[5*AW +: PW];
    assign w_has      = mem_rd[DW-1];
    assign w_rd_child = f_child(mem_rd, r_req.base);

    always_ff @(posedge i_clk) begin
        mem_we <= 1'b0;
        r_qwe  <= 1'b0;
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_init       <= 1'b1;
            r_clr        <= '0;
            r_out_valid  <= 1'b0;
            r_node_count <= '0;
            r_cursor     <= '0;
            r_match      <= '0;
        end else begin
            // load the response register when it is free, drop it once taken
            if (r_state == S_OUT && (!r_out_valid || o_rsp.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_req <= i_req.data;
                        r_rsp <= '0;
                        unique case (i_req.data.action)
                            ACT_CLEAR: begin
                                r_clr   <= '0;
                                r_state <= S_CLEAR;
                                r_node_count <= '0;
                                r_cursor <= '0;
                                r_match  <= '0;
                            end
                            ACT_INSERT: begin
                                mem_ra  <= r_cursor;
                                r_cur   <= r_cursor;
                                r_state <= S_IWAIT;
                            end
                            ACT_BUILD: begin
                                r_head  <= '0;
                                r_tail  <= (AW+1)'(1);
                                r_qwe   <= 1'b1;
                                r_qwa   <= '0;
                                r_qwd   <= '0;
                                r_state <= S_BINIT;
                            end
                            default: begin
                                mem_ra  <= r_match;
                                r_cur   <= r_match;
                                r_hops  <= '0;
                                r_state <= S_MWAIT;
                            end
                        endcase
                    end
                end
                S_CLEAR: begin
                    // sweep zeros, one node a cycle
                    mem_we <= 1'b1;
                    mem_wa <= r_clr[AW-1:0];
                    mem_wd <= '0;
                    r_clr  <= r_clr + 1'b1;
                    if (r_clr == (AW+1)'(NODES - 1)) begin
                        r_state <= r_init ? S_IDLE : S_OUT;
                        r_init  <= 1'b0;
                    end
                end
                S_IRD: r_state <= S_IWAIT;
                S_IWAIT: r_state <= S_IUPD;
                S_IUPD: begin
                    logic [AW-1:0] c;
                    logic [DW-1:0] w;
                    c = w_rd_child;
                    w = mem_rd;
                    if (c != '0) begin
                        r_rsp.node <= NODE_W'(c);
                        r_cursor   <= r_req.pattern_end ? '0 : c;
                        r_cur      <= c;
                        if (r_req.pattern_end) begin
                            mem_ra  <= c;
                            r_state <= S_INEW;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end else if (r_node_count + 1'b1 >= (AW+1)'(NODES)) begin
                        r_rsp.status <= 1'b1;
                        r_rsp.node   <= NODE_W'(r_cur);
                        r_cursor     <= r_req.pattern_end ? '0 : r_cur;
                        r_state      <= S_OUT;
                    end else begin
                        c = AW'(r_node_count + 1'b1);
                        r_node_count <= r_node_count + 1'b1;
                        w[r_req.base*AW +: AW] = c;
                        mem_we <= 1'b1;
                        mem_wa <= r_cur;
                        mem_wd <= w;
                        r_rsp.node <= NODE_W'(c);
                        r_cursor   <= r_req.pattern_end ? '0 : c;
                        r_cur      <= c;
                        if (r_req.pattern_end) begin
                            mem_ra  <= c;
                            r_state <= S_INEW;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                    r_hops <= '0;
                end
                S_INEW: begin
                    // wait for word of end node, then mark pattern
                    if (r_hops == '0) begin
                        r_hops <= (AW+1)'(1);
                    end else begin
                        if (r_req.pattern_id >= 4'd1 &&
                            32'(r_req.pattern_id) <= PATTERNS) begin
                            logic [DW-1:0] w;
                            w = mem_rd;
                            w[5*AW +: PW] = r_req.pattern_id;
                            w[DW-1] = 1'b1;
                            mem_we <= 1'b1;
                            mem_wa <= r_cur;
                            mem_wd <= w;
                            r_pw[r_req.pattern_id - 4'd1] <= r_req.weight;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_MRD: r_state <= S_MWAIT;
                S_MWAIT: r_state <= S_MSTEP;
                S_MSTEP: begin
                    if (r_cur != '0 && w_rd_child == '0 && r_hops != (AW+1)'(NODES)) begin
                        r_hops <= r_hops + 1'b1;
                        r_cur  <= w_fail;
                        mem_ra <= w_fail;
                        r_state <= S_MRD;
                    end else begin
                        r_match    <= w_rd_child;
                        r_rsp.node <= NODE_W'(w_rd_child);
                        r_cur      <= w_rd_child;
                        mem_ra     <= w_rd_child;
                        r_hops     <= '0;
                        r_mask     <= '0;
                        r_state    <= S_ORD;
                    end
                end
                S_ORD: r_state <= S_OWAIT;
                S_OWAIT: r_state <= S_OSTEP;
                S_OSTEP: begin
                    if (w_has && r_hops != (AW+1)'(NODES)) begin
                        if (w_pat >= 4'd1 && 32'(w_pat) <= PATTERNS) begin
                            r_mask[w_pat - 4'd1] <= 1'b1;
                        end
                        r_hops <= r_hops + 1'b1;
                        mem_ra <= w_fail;
                        r_state <= S_ORD;
                    end else begin
                        r_sum_i <= '0;
                        r_sum   <= '0;
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    // accumulate one weight per cycle
                    if (r_mask[r_sum_i]) begin
                        r_sum <= r_sum + r_pw[r_sum_i];
                    end
                    if (r_sum_i == CW'(PATTERNS - 1)) begin
                        r_state <= S_OUT;
                    end
                    r_sum_i <= r_sum_i + 1'b1;
                end
                S_OUT: begin
                    // hold here while the previous response still waits
                    t_rsp rsp;
                    rsp = r_rsp;
                    if (r_req.action == ACT_MATCH) begin
                        rsp.matched_mask = MASK_W'(r_mask);
                        rsp.match_weight = r_sum;
                    end
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out   <= rsp;
                        r_state <= S_IDLE;
                    end
                end
                S_BINIT: begin
                    // let the root entry land in the queue before the first pop
                    r_state <= S_BPOP;
                end
                S_BPOP: begin
                    if (r_head == r_tail) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_BUWAIT;
                    end
                end
                S_BUWAIT: begin
                    // r_qrd now holds queue head
                    mem_ra  <= r_qrd;
                    r_u     <= r_qrd;
                    r_head  <= r_head + 1'b1;
                    r_k     <= BASE_A;
                    r_hops  <= '0;
                    r_state <= S_BUGOT;
                end
                S_BUGOT: begin
                    if (r_hops == '0) begin
                        r_hops <= (AW+1)'(1);
                    end else begin
                        r_uword <= mem_rd;
                        r_state <= S_BVWAIT;
                    end
                end
                S_BVWAIT: begin
                    // pick child k of u
                    if (f_child(r_uword, r_k) == '0) begin
                        r_state <= S_BNEXT;
                    end else begin
                        r_v    <= f_child(r_uword, r_k);
                        r_cur  <= r_uword[4*AW +: AW];
                        mem_ra <= r_uword[4*AW +: AW];
                        r_hops <= '0;
                        r_state <= S_BVGOT;
                    end
                end
                S_BVGOT: r_state <= S_BPWAIT;
                S_BPWAIT: begin
                    // mem_rd is word of p = r_cur
                    if (r_cur != '0 && f_child(mem_rd, r_k) == '0 &&
                        r_hops != (AW+1)'(NODES)) begin
                        r_hops <= r_hops + 1'b1;
                        r_cur  <= w_fail;
                        mem_ra <= w_fail;
                        r_state <= S_BVGOT;
                    end else begin
                        logic [AW-1:0] c;
                        c = f_child(mem_rd, r_k);
                        if (c != '0 && c != r_v) begin
                            r_cur  <= c;
                            mem_ra <= c;
                            r_hops <= '0;
                            r_state <= S_BPGOT;
                        end else begin
                            r_word <= mem_rd;
                            mem_ra <= r_v;
                            r_hops <= '0;
                            r_state <= S_BWV;
                        end
                    end
                end
                S_BPGOT: begin
                    if (r_hops == '0) begin
                        r_hops <= (AW+1)'(1);
                    end else begin
                        r_word <= mem_rd;
                        mem_ra <= r_v;
                        r_hops <= '0;
                        r_state <= S_BWV;
                    end
                end
                S_BWV: begin
                    // r_word is the word of the fail target r_cur, read v then write fail and output mark
                    if (r_hops == '0) begin
                        r_hops <= (AW+1)'(1);
                    end else begin
                        logic [DW-1:0] w;
                        w = mem_rd;
                        w[4*AW +: AW] = r_cur;
                        w[DW-1] = mem_rd[DW-1] | r_word[DW-1];
                        mem_we <= 1'b1;
                        mem_wa <= r_v;
                        mem_wd <= w;
                        if (r_u == r_v) begin
                            r_uword <= w;
                        end
                        if (r_tail < (AW+1)'(NODES)) begin
                            r_qwe  <= 1'b1;
                            r_qwa  <= r_tail[AW-1:0];
                            r_qwd  <= r_v;
                            r_tail <= r_tail + 1'b1;
                        end
                        r_state <= S_BNEXT;
                    end
                end
                S_BNEXT: begin
                    if (r_k == BASE_G) begin
                        r_state <= S_BPOP;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_BVWAIT;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### hdl/dmpm_checker.sv
// ----------------------------------------------------------------------------
// dmpm_checker
// Port-level checks of the matcher's handshakes.
// ----------------------------------------------------------------------------
`include "dna_multi_pattern_matcher_core_defines.svh"
module dmpm_checker
    import dmpm_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input t_rsp i_out_data
);
    `DMPM_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "ready stayed high after accept")
    `DMPM_ASSERT_NOW(a_out_known, i_clk, i_rst_n, i_out_valid, !$isunknown(i_out_data), "response carries unknown bits")
    `DMPM_ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result dropped")
    `DMPM_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_data), "result changed while waiting")
endmodule

bind dna_multi_pattern_matcher_core dmpm_checker u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_req.valid),
    .i_in_ready (i_req.ready),
    .i_out_valid(o_rsp.valid),
    .i_out_ready(o_rsp.ready),
    .i_out_data (o_rsp.data)
);
